// ===== rtl/cube_map_texel_lookup_core_defines.svh =====
// ----------------------------------------------------------------------------
// Cube map texel lookup: assertion macros
// Shared concurrent assertion forms used by the lookup core.
// ----------------------------------------------------------------------------
`ifndef CUBE_MAP_TEXEL_LOOKUP_CORE_DEFINES_SVH
`define CUBE_MAP_TEXEL_LOOKUP_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CML_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cube map lookup check failed");

// Next-cycle implication, disabled while in reset.
`define CML_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cube map lookup check failed");

`endif

// ===== rtl/cml_pkg.sv =====
// ----------------------------------------------------------------------------
// Cube map texel lookup package
// Shared types and fixed constants of the cube map lookup core.
// ----------------------------------------------------------------------------
package cml_pkg;

   localparam int TEXEL_WIDTH = 32;
   localparam int FACE_WIDTH  = 3;
   localparam int NUM_FACES   = 6;
   localparam int CSR_WIDTH   = 7;

   // Face codes: twice the major axis, plus one when that axis is negative.
   localparam logic [FACE_WIDTH-1:0] FACE_POS_X = 3'd0;
   localparam logic [FACE_WIDTH-1:0] FACE_NEG_X = 3'd1;
   localparam logic [FACE_WIDTH-1:0] FACE_POS_Y = 3'd2;
   localparam logic [FACE_WIDTH-1:0] FACE_NEG_Y = 3'd3;
   localparam logic [FACE_WIDTH-1:0] FACE_POS_Z = 3'd4;
   localparam logic [FACE_WIDTH-1:0] FACE_NEG_Z = 3'd5;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_WRITE  = 1'b1
   } cml_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_LOAD,
      ST_DIVIDE,
      ST_ADDR,
      ST_READ,
      ST_OUT
   } cml_state_type;

   typedef struct packed {
      logic [TEXEL_WIDTH-1:0] red;
      logic [TEXEL_WIDTH-1:0] green;
      logic [TEXEL_WIDTH-1:0] blue;
   } cml_texel_type;

endpackage

// ===== rtl/cml_if.sv =====
// ----------------------------------------------------------------------------
// Cube map texel lookup channels
// Valid/ready channels for requests, responses and the face size register.
// ----------------------------------------------------------------------------
interface cml_req_if import cml_pkg::*; #(
   parameter int DIR_WIDTH   = 16,
   parameter int COORD_WIDTH = 6
);
   logic                    valid;
   logic                    ready;
   logic                    opcode;
   logic signed [DIR_WIDTH-1:0] dir_x;
   logic signed [DIR_WIDTH-1:0] dir_y;
   logic signed [DIR_WIDTH-1:0] dir_z;
   logic [FACE_WIDTH-1:0]   write_face;
   logic [COORD_WIDTH-1:0]  write_row;
   logic [COORD_WIDTH-1:0]  write_col;
   logic [TEXEL_WIDTH-1:0]  texel_red;
   logic [TEXEL_WIDTH-1:0]  texel_green;
   logic [TEXEL_WIDTH-1:0]  texel_blue;

   modport source (
      output valid, opcode, dir_x, dir_y, dir_z, write_face, write_row, write_col,
             texel_red, texel_green, texel_blue,
      input  ready
   );
   modport sink (
      input  valid, opcode, dir_x, dir_y, dir_z, write_face, write_row, write_col,
             texel_red, texel_green, texel_blue,
      output ready
   );
endinterface

interface cml_rsp_if import cml_pkg::*; #(
   parameter int COORD_WIDTH = 6
);
   logic                   valid;
   logic                   ready;
   logic [TEXEL_WIDTH-1:0] red_out;
   logic [TEXEL_WIDTH-1:0] green_out;
   logic [TEXEL_WIDTH-1:0] blue_out;
   logic [FACE_WIDTH-1:0]  face_out;
   logic [COORD_WIDTH-1:0] col_out;
   logic [COORD_WIDTH-1:0] row_out;
   logic                   zero_direction;

   modport source (
      output valid, red_out, green_out, blue_out, face_out, col_out, row_out,
             zero_direction,
      input  ready
   );
   modport sink (
      input  valid, red_out, green_out, blue_out, face_out, col_out, row_out,
             zero_direction,
      output ready
   );
endinterface

interface cml_csr_if #(
   parameter int DATA_WIDTH = 7
);
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] face_size;

   modport source (output valid, face_size, input ready);
   modport sink   (input valid, face_size, output ready);
endinterface

// ===== rtl/cml_ram.sv =====
// ----------------------------------------------------------------------------
// Cube map texel lookup RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module cml_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 24576,
   localparam int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cml_coord_div.sv =====
// ----------------------------------------------------------------------------
// Cube map coordinate divider
// Serial unit that maps one minor component to a clamped texel coordinate,
// floor((c' + |m|) * size / (2 * |m|)), one quotient digit per cycle.
// ----------------------------------------------------------------------------
module cml_coord_div #(
   parameter int DIR_WIDTH     = 16,
   parameter int MAX_FACE_SIZE = 64,
   localparam int SIZE_WIDTH   = $clog2(MAX_FACE_SIZE + 1),
   localparam int COORD_WIDTH  = (MAX_FACE_SIZE > 1) ? $clog2(MAX_FACE_SIZE) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [DIR_WIDTH-1:0] coord,
   input  logic [DIR_WIDTH-1:0]        major_mag,
   input  logic                        major_neg,
   input  logic [SIZE_WIDTH-1:0]       face_size,
   output logic                        busy,
   output logic [COORD_WIDTH-1:0]      coord_out
);

   localparam int NUM_WIDTH = DIR_WIDTH + 1;
   localparam int SUM_WIDTH = DIR_WIDTH + 2;
   localparam int TRY_WIDTH = DIR_WIDTH + 3;
   localparam int QUO_WIDTH = SIZE_WIDTH + 1;
   localparam int CNT_WIDTH = (SIZE_WIDTH > 1) ? $clog2(SIZE_WIDTH) : 1;

   logic                  busy_ff, busy_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [NUM_WIDTH-1:0]  num_ff, num_in;
   logic [NUM_WIDTH-1:0]  dvs_ff, dvs_in;
   logic [NUM_WIDTH-1:0]  rem_ff, rem_in;
   logic [SIZE_WIDTH-1:0] quo_ff, quo_in;
   logic [SIZE_WIDTH-1:0] bits_ff, bits_in;
   logic [SIZE_WIDTH-1:0] size_ff, size_in;

   logic [SUM_WIDTH-1:0]  mag_ext;
   logic [SUM_WIDTH-1:0]  coord_ext;
   logic [SUM_WIDTH-1:0]  num_sum;
   logic [TRY_WIDTH-1:0]  trial;
   logic [TRY_WIDTH-1:0]  dvs_one;
   logic [TRY_WIDTH-1:0]  dvs_two;
   logic [1:0]            digit;
   logic [QUO_WIDTH-1:0]  quo_wide;

   // The numerator c' + |m| lies in 0 .. 2|m|; it is formed as |m| - c or |m| + c.
   always_comb begin
      mag_ext   = {2'b00, major_mag};
      coord_ext = SUM_WIDTH'(coord);
      num_sum   = major_neg ? (mag_ext - coord_ext) : (mag_ext + coord_ext);
   end

   // Each step takes one bit of the size, MSB first: the partial product doubles
   // and gains the numerator, so the remainder stays below three divisors and
   // the quotient digit is 0, 1 or 2.
   always_comb begin
      trial   = {1'b0, rem_ff, 1'b0} + (bits_ff[SIZE_WIDTH-1] ? {2'b00, num_ff} : '0);
      dvs_one = {2'b00, dvs_ff};
      dvs_two = {1'b0, dvs_ff, 1'b0};
      if (trial >= dvs_two) begin
         digit  = 2'd2;
         rem_in = NUM_WIDTH'(trial - dvs_two);
      end else if (trial >= dvs_one) begin
         digit  = 2'd1;
         rem_in = NUM_WIDTH'(trial - dvs_one);
      end else begin
         digit  = 2'd0;
         rem_in = NUM_WIDTH'(trial);
      end
      quo_wide = QUO_WIDTH'({quo_ff, 1'b0}) + QUO_WIDTH'(digit);
      quo_in   = quo_wide[SIZE_WIDTH-1:0];
      bits_in  = bits_ff << 1;
      cnt_in   = cnt_ff - 1'b1;
      busy_in  = (cnt_ff != '0);
      num_in   = num_sum[NUM_WIDTH-1:0];
      dvs_in   = {major_mag, 1'b0};
      size_in  = face_size;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff  <= num_in;
         dvs_ff  <= dvs_in;
         size_ff <= size_in;
         bits_ff <= size_in;
         rem_ff  <= '0;
         quo_ff  <= '0;
         cnt_ff  <= CNT_WIDTH'(SIZE_WIDTH - 1);
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         bits_ff <= bits_in;
         cnt_ff  <= cnt_in;
      end
   end

   // A component equal to the major one lands exactly on size; clamp it.
   logic [SIZE_WIDTH-1:0] clamped;
   assign clamped   = (quo_ff >= size_ff) ? (size_ff - 1'b1) : quo_ff;
   assign coord_out = clamped[COORD_WIDTH-1:0];
   assign busy      = busy_ff;

endmodule

// ===== rtl/cube_map_texel_lookup_core.sv =====
// ----------------------------------------------------------------------------
// Cube map texel lookup core
// Six square faces of RGB texels, loaded by write beats and read back by
// direction vector lookups.
//
// Channels: req_bus carries one item per beat, either a texel write or a
// lookup by direction. rsp_bus returns one beat per lookup and none per write.
// csr_bus sets the face edge length; it is always ready. The user must write it
// only while the core is idle; the core itself does not enforce this.
// Writes: one beat per cycle while the core is idle; the RAM is written in the
// cycle after acceptance. Lookups: after the setup and load states, the two
// coordinate dividers run side by side and each retires one quotient digit
// per cycle; an address state and one RAM read follow, and the response is
// loaded in the output state. The next request is taken only once the core
// is back in idle, so a new lookup is not started before the last one is done.
// An all-zero direction skips the dividers and the RAM.
// Reset clears the control state and sets face_size to 1; texel contents are
// undefined until written. A stalled response sits in the output register
// while the next request is already taken and processed up to its own result.
// ----------------------------------------------------------------------------
`include "cube_map_texel_lookup_core_defines.svh"

module cube_map_texel_lookup_core import cml_pkg::*; #(
   parameter int MAX_FACE_SIZE = 64,
   parameter int DIR_WIDTH     = 16
) (
   input  logic      clock,
   input  logic      reset,
   cml_csr_if.sink   csr_bus,
   cml_req_if.sink   req_bus,
   cml_rsp_if.source rsp_bus
);

   localparam int SIZE_WIDTH  = $clog2(MAX_FACE_SIZE + 1);
   localparam int COORD_WIDTH = (MAX_FACE_SIZE > 1) ? $clog2(MAX_FACE_SIZE) : 1;
   localparam int CMP_WIDTH   = COORD_WIDTH + 1;
   localparam int FACE_AREA   = MAX_FACE_SIZE * MAX_FACE_SIZE;
   localparam int STORE_DEPTH = NUM_FACES * FACE_AREA;
   localparam int ADDR_WIDTH  = $clog2(STORE_DEPTH);
   localparam int TEXEL_BITS  = $bits(cml_texel_type);

   // ---- control state ----
   cml_state_type            state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     wr_en_ff, wr_en_in;
   logic [CSR_WIDTH-1:0]     face_size_ff;

   // ---- payload ----
   logic signed [DIR_WIDTH-1:0] dir_x_ff, dir_y_ff, dir_z_ff;
   logic [FACE_WIDTH-1:0]       face_ff;
   logic                        zero_ff;
   logic [DIR_WIDTH-1:0]        mag_ff;
   logic                        neg_ff;
   logic signed [DIR_WIDTH-1:0] ca_ff, cb_ff;
   logic [ADDR_WIDTH-1:0]       wr_addr_ff, wr_addr_in;
   cml_texel_type               wr_data_ff;
   logic [ADDR_WIDTH-1:0]       rd_addr_ff, rd_addr_in;
   cml_texel_type               rsp_texel_ff;
   logic [FACE_WIDTH-1:0]       rsp_face_ff;
   logic [COORD_WIDTH-1:0]      rsp_col_ff, rsp_row_ff;
   logic                        rsp_zero_ff;

   // ---- combinational ----
   logic                        req_ready;
   logic                        req_accept;
   logic                        div_start;
   logic                        rd_en;
   logic                        rsp_load;
   logic [SIZE_WIDTH-1:0]       size_eff;
   logic                        wr_in_range;
   logic [DIR_WIDTH-1:0]        abs_x, abs_y, abs_z;
   logic [FACE_WIDTH-1:0]       setup_face;
   logic                        setup_zero;
   logic [DIR_WIDTH-1:0]        setup_mag;
   logic                        setup_neg;
   logic signed [DIR_WIDTH-1:0] setup_ca, setup_cb;
   logic                        col_busy, row_busy;
   logic [COORD_WIDTH-1:0]      col_q, row_q;
   logic [TEXEL_BITS-1:0]       rd_data;
   cml_texel_type               rd_texel;

   assign req_accept  = req_bus.valid && req_ready;
   assign req_bus.ready = req_ready;
   assign csr_bus.ready = 1'b1;

   // Face sizes outside 1..MAX_FACE_SIZE are pinned to the nearest end.
   assign size_eff = (face_size_ff == '0) ? SIZE_WIDTH'(1) :
                     (int'(face_size_ff) > MAX_FACE_SIZE) ?
                        SIZE_WIDTH'(MAX_FACE_SIZE) : SIZE_WIDTH'(face_size_ff);

   // ---- texel write address ----
   always_comb begin
      wr_in_range = (req_bus.write_face < FACE_WIDTH'(NUM_FACES)) &&
                    ({1'b0, req_bus.write_row} < CMP_WIDTH'(MAX_FACE_SIZE)) &&
                    ({1'b0, req_bus.write_col} < CMP_WIDTH'(MAX_FACE_SIZE));
      wr_addr_in  = ADDR_WIDTH'(FACE_AREA) * ADDR_WIDTH'(req_bus.write_face) +
                    ADDR_WIDTH'(MAX_FACE_SIZE) * ADDR_WIDTH'(req_bus.write_row) +
                    ADDR_WIDTH'(req_bus.write_col);
      wr_en_in    = req_accept && (req_bus.opcode == OP_WRITE) && wr_in_range;
   end

   // ---- major axis selection ----
   always_comb begin
      abs_x      = dir_x_ff[DIR_WIDTH-1] ? (~dir_x_ff + 1'b1) : dir_x_ff;
      abs_y      = dir_y_ff[DIR_WIDTH-1] ? (~dir_y_ff + 1'b1) : dir_y_ff;
      abs_z      = dir_z_ff[DIR_WIDTH-1] ? (~dir_z_ff + 1'b1) : dir_z_ff;
      setup_zero = (dir_x_ff == '0) && (dir_y_ff == '0) && (dir_z_ff == '0);
      if ((abs_x >= abs_y) && (abs_x >= abs_z)) begin
         setup_mag  = abs_x;
         setup_neg  = dir_x_ff[DIR_WIDTH-1];
         setup_ca   = dir_y_ff;
         setup_cb   = dir_z_ff;
         setup_face = setup_neg ? FACE_NEG_X : FACE_POS_X;
      end else if (abs_y >= abs_z) begin
         setup_mag  = abs_y;
         setup_neg  = dir_y_ff[DIR_WIDTH-1];
         setup_ca   = dir_x_ff;
         setup_cb   = dir_z_ff;
         setup_face = setup_neg ? FACE_NEG_Y : FACE_POS_Y;
      end else begin
         setup_mag  = abs_z;
         setup_neg  = dir_z_ff[DIR_WIDTH-1];
         setup_ca   = dir_x_ff;
         setup_cb   = dir_y_ff;
         setup_face = setup_neg ? FACE_NEG_Z : FACE_POS_Z;
      end
   end

   assign rd_addr_in = ADDR_WIDTH'(FACE_AREA) * ADDR_WIDTH'(face_ff) +
                       ADDR_WIDTH'(MAX_FACE_SIZE) * ADDR_WIDTH'(row_q) +
                       ADDR_WIDTH'(col_q);

   // ---- sequencer ----
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      div_start = 1'b0;
      rd_en     = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_bus.valid && (req_bus.opcode == OP_LOOKUP)) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (zero_ff) begin
               state_in = ST_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (!col_busy && !row_busy) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wr_en_ff     <= 1'b0;
         face_size_ff <= CSR_WIDTH'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_en_ff     <= wr_en_in;
         if (csr_bus.valid) begin
            face_size_ff <= csr_bus.face_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && (req_bus.opcode == OP_LOOKUP)) begin
         dir_x_ff <= req_bus.dir_x;
         dir_y_ff <= req_bus.dir_y;
         dir_z_ff <= req_bus.dir_z;
      end
      if (req_accept) begin
         wr_addr_ff       <= wr_addr_in;
         wr_data_ff.red   <= req_bus.texel_red;
         wr_data_ff.green <= req_bus.texel_green;
         wr_data_ff.blue  <= req_bus.texel_blue;
      end
      if (state_ff == ST_SETUP) begin
         face_ff <= setup_face;
         zero_ff <= setup_zero;
         mag_ff  <= setup_mag;
         neg_ff  <= setup_neg;
         ca_ff   <= setup_ca;
         cb_ff   <= setup_cb;
      end
      if (state_ff == ST_ADDR) begin
         rd_addr_ff <= rd_addr_in;
      end
      if (rsp_load) begin
         rsp_texel_ff <= zero_ff ? '0 : rd_texel;
         rsp_face_ff  <= zero_ff ? '0 : face_ff;
         rsp_col_ff   <= zero_ff ? '0 : col_q;
         rsp_row_ff   <= zero_ff ? '0 : row_q;
         rsp_zero_ff  <= zero_ff;
      end
   end

   // ---- coordinate dividers: column from the first minor axis, row from the second ----
   cml_coord_div #(
      .DIR_WIDTH     (DIR_WIDTH),
      .MAX_FACE_SIZE (MAX_FACE_SIZE)
   ) u_col_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .coord     (ca_ff),
      .major_mag (mag_ff),
      .major_neg (neg_ff),
      .face_size (size_eff),
      .busy      (col_busy),
      .coord_out (col_q)
   );

   cml_coord_div #(
      .DIR_WIDTH     (DIR_WIDTH),
      .MAX_FACE_SIZE (MAX_FACE_SIZE)
   ) u_row_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .coord     (cb_ff),
      .major_mag (mag_ff),
      .major_neg (neg_ff),
      .face_size (size_eff),
      .busy      (row_busy),
      .coord_out (row_q)
   );

   // ---- texel store ----
   cml_ram #(
      .WIDTH (TEXEL_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_texel_ram (
      .clock   (clock),
      .wr_en   (wr_en_ff),
      .wr_addr (wr_addr_ff),
      .wr_data (wr_data_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   assign rd_texel = rd_data;

   // ---- response outputs ----
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.red_out        = rsp_texel_ff.red;
   assign rsp_bus.green_out      = rsp_texel_ff.green;
   assign rsp_bus.blue_out       = rsp_texel_ff.blue;
   assign rsp_bus.face_out       = rsp_face_ff;
   assign rsp_bus.col_out        = rsp_col_ff;
   assign rsp_bus.row_out        = rsp_row_ff;
   assign rsp_bus.zero_direction = rsp_zero_ff;

   // ---- assertions ----
`CML_ASSERT_IMPLY(a_div_only_in_divide, clock, reset, col_busy || row_busy, state_ff == ST_DIVIDE)
`CML_ASSERT_NEXT(a_lookup_starts_setup, clock, reset, req_accept && (req_bus.opcode == OP_LOOKUP), state_ff == ST_SETUP)
`CML_ASSERT_IMPLY(a_write_while_idle, clock, reset, wr_en_ff, state_ff == ST_IDLE)
`CML_ASSERT_IMPLY(a_rsp_from_out_state, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_OUT)

endmodule
